>>> src/rhs_pkg.sv
// Shared types and constants for the rolling-hash substring search block.
// Used by every module under src; depends on nothing else.
package rhs_pkg;

    localparam int LEN_W   = 6;
    localparam int MOD_W   = 31;
    localparam int PAT_W   = 256;
    localparam int CNT_W   = 25;
    localparam int FND_W   = 21;
    localparam int START_W = 20;
    localparam int IDX_W   = 3;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;
    localparam logic [MOD_W-1:0] MOD_RESET = 31'd101;
    localparam logic [MOD_W-1:0] MOD_MIN   = 31'd2;
    localparam logic [CNT_W-1:0] CNT_SAT   = 25'h1FFFFFF;
    localparam logic [FND_W-1:0] FND_SAT   = 21'h1FFFFF;

    typedef enum logic [IDX_W-1:0] {
        REG_LEN    = 3'd0,
        REG_MOD    = 3'd1,
        REG_WORD_0 = 3'd2,
        REG_WORD_1 = 3'd3,
        REG_WORD_2 = 3'd4,
        REG_WORD_3 = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_SHIFT = 3'd2,
        OP_ADD   = 3'd3,
        OP_SUBR  = 3'd4
    } red_op_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0] pattern_length;
        logic [MOD_W-1:0] hash_modulus;
        logic [PAT_W-1:0] pattern_bits;
    } cfg_t;

endpackage

>>> src/rolling_hash_substring_search_top.sv
// Top level of the rolling-hash substring search: configuration registers, queue and back end.
// Depends on rhs_pkg, rhs_front and rhs_back.
//
//   channel   signals                      direction
//   input     in_valid/in_ready            text_byte, text_end in
//   output    out_valid/out_ready          one result per byte out
//   config    cfg_valid/cfg_ready          cfg_index, cfg_data in
//
// The first byte of a text first forms the pattern hash and the leading factor in the shared
// modular unit. A byte makes 8 hash shifts while the window fills; once it is full, the
// leading-byte product (16 unit steps) and a subtraction come before the 8 hash shifts.
// Reset is asynchronous and leaves the block idle; the configuration port never stalls.
// A stalled output holds the back end, while a two-entry queue accepts input until it is full.
module rolling_hash_substring_search_top
    import rhs_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int TEXT_MAX    = 1048576
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         text_byte,
    input  logic               text_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               window_full,
    output logic               hash_hit,
    output logic               found,
    output logic [START_W-1:0] match_start,
    output logic [LEN_W-1:0]   compares_now,
    output logic [CNT_W-1:0]   compare_total,
    output logic [FND_W-1:0]   found_total,
    output logic               final_res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [63:0]        cfg_data
);

    logic [LEN_W-1:0] len_reg;
    logic [MOD_W-1:0] mod_reg;
    logic [63:0]      word_reg [4];
    cfg_t             cfg;
    item_t            in_item;
    item_t            q_item;
    logic             q_valid;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
            mod_reg <= MOD_RESET;
            for (int i = 0; i < 4; i++)
            begin
                word_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LEN:    len_reg     <= cfg_data[LEN_W-1:0];
                REG_MOD:    mod_reg     <= cfg_data[MOD_W-1:0];
                REG_WORD_0: word_reg[0] <= cfg_data;
                REG_WORD_1: word_reg[1] <= cfg_data;
                REG_WORD_2: word_reg[2] <= cfg_data;
                REG_WORD_3: word_reg[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.pattern_length = len_reg;
    assign cfg.hash_modulus   = mod_reg;
    assign cfg.pattern_bits   = {word_reg[3], word_reg[2], word_reg[1], word_reg[0]};

    assign in_item.text_byte = text_byte;
    assign in_item.text_end  = text_end;

    rhs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    rhs_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .window_full   (window_full),
        .hash_hit      (hash_hit),
        .found         (found),
        .match_start   (match_start),
        .compares_now  (compares_now),
        .compare_total (compare_total),
        .found_total   (found_total),
        .final_res     (final_res)
    );

`ifndef ASSERT_OFF
    // An exact match is only reported for a full window whose hash agreed.
    a_found_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!found || hash_hit) && (!hash_hit || window_full))
        else $error("found without hash hit or hit without full window");

    // Comparisons are only made on a hash hit, and at least one is made then.
    a_compares_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hash_hit == (compares_now != '0)))
        else $error("compares_now does not agree with hash_hit");

    // A match compares every pattern byte, which is never more than the window size.
    a_compares_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (compares_now <= LEN_W'(PATTERN_MAX)))
        else $error("compares_now beyond the pattern size");
`endif

endmodule

>>> src/rhs_front.sv
// Input side: a two-entry queue that accepts text bytes and hands them to the back end.
// Depends on rhs_pkg.
module rhs_front
    import rhs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_pop
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> src/rhs_modred.sv
// Iterative modular unit: one load, shift-in, add or reverse-subtract modulo q per cycle.
// Depends on rhs_pkg.
module rhs_modred
    import rhs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  red_op_t          op,
    input  logic             bit_in,
    input  logic [MOD_W-1:0] operand,
    input  logic [MOD_W-1:0] modulus,
    output logic [MOD_W-1:0] acc
);

    logic [MOD_W-1:0] acc_reg;
    logic [MOD_W-1:0] acc_next;
    logic [MOD_W:0]   dbl;
    logic [MOD_W:0]   sum;
    logic [MOD_W:0]   dif;
    logic [MOD_W:0]   q_ext;

    assign acc = acc_reg;

    always_comb
    begin
        q_ext = {1'b0, modulus};
        dbl   = {acc_reg, bit_in};
        sum   = {1'b0, acc_reg} + {1'b0, operand};
        // Both values are below q, so one correction brings the result into range.
        if (operand >= acc_reg)
        begin
            dif = {1'b0, operand} - {1'b0, acc_reg};
        end
        else
        begin
            dif = {1'b0, operand} + q_ext - {1'b0, acc_reg};
        end
        unique case (op)
            OP_LOAD:  acc_next = operand;
            OP_SHIFT: acc_next = (dbl >= q_ext) ? MOD_W'(dbl - q_ext) : dbl[MOD_W-1:0];
            OP_ADD:   acc_next = (sum >= q_ext) ? MOD_W'(sum - q_ext) : sum[MOD_W-1:0];
            OP_SUBR:  acc_next = dif[MOD_W-1:0];
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

>>> src/rhs_back.sv
// Back end: sequencer that opens a text, rolls the hash, checks the window and emits results.
// Depends on rhs_pkg and rhs_modred.
module rhs_back
    import rhs_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int TEXT_MAX    = 1048576
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               window_full,
    output logic               hash_hit,
    output logic               found,
    output logic [START_W-1:0] match_start,
    output logic [LEN_W-1:0]   compares_now,
    output logic [CNT_W-1:0]   compare_total,
    output logic [FND_W-1:0]   found_total,
    output logic               final_res
);

    localparam int POS_W = $clog2(TEXT_MAX);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_MAX - 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_PREP = 12'b0000_0000_0010,
        S_TCAP = 12'b0000_0000_0100,
        S_LFAC = 12'b0000_0000_1000,
        S_LCAP = 12'b0000_0001_0000,
        S_PROC = 12'b0000_0010_0000,
        S_LEAD = 12'b0000_0100_0000,
        S_SUBT = 12'b0000_1000_0000,
        S_HSH  = 12'b0001_0000_0000,
        S_WUPD = 12'b0010_0000_0000,
        S_CHK  = 12'b0100_0000_0000,
        S_EMIT = 12'b1000_0000_0000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [7:0]       k_reg;
    logic [7:0]       k_next;
    logic [LEN_W-1:0] m_reg;
    logic [MOD_W-1:0] q_reg;
    logic             open_reg;
    logic [MOD_W-1:0] wh_reg;
    logic [MOD_W-1:0] target_reg;
    logic [MOD_W-1:0] lf_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [POS_W-1:0] pos_reg;
    logic [CNT_W-1:0] cc_reg;
    logic [FND_W-1:0] fc_reg;
    logic [7:0]       win_reg [PATTERN_MAX];

    logic               r_full_reg;
    logic               r_hit_reg;
    logic               r_fnd_reg;
    logic [START_W-1:0] r_start_reg;
    logic [LEN_W-1:0]   r_now_reg;

    logic               out_valid_reg;
    logic               full_reg;
    logic               hit_reg;
    logic               fnd_reg;
    logic [START_W-1:0] start_reg;
    logic [LEN_W-1:0]   now_reg;
    logic [CNT_W-1:0]   ctot_reg;
    logic [FND_W-1:0]   ftot_reg;
    logic               fin_reg;

    red_op_t          red_op;
    logic             red_bit;
    logic [MOD_W-1:0] red_operand;
    logic [MOD_W-1:0] red_acc;

    logic [LEN_W-1:0] m_new;
    logic [MOD_W-1:0] q_new;
    logic [8:0]       last_tgt;
    logic [8:0]       last_lf;
    logic             emit_go;
    logic             mism;
    logic [LEN_W-1:0] mism_idx;
    logic [LEN_W-1:0] now_c;
    logic             full_c;
    logic             hit_c;
    logic [30:0]      pos_w;
    logic [30:0]      mm1;
    logic [30:0]      start_c;
    logic [CNT_W:0]   cc_sum;

    rhs_modred u_modred
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (red_op),
        .bit_in  (red_bit),
        .operand (red_operand),
        .modulus (q_reg),
        .acc     (red_acc)
    );

    assign m_new    = (cfg.pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                                  : cfg.pattern_length;
    assign q_new    = (cfg.hash_modulus < MOD_MIN) ? MOD_MIN : cfg.hash_modulus;
    assign last_tgt = {m_reg[5:0], 3'b000} - 9'd1;
    assign last_lf  = {m_reg[5:0], 3'b000} - 9'd9;
    assign emit_go  = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign q_pop    = emit_go;

    // Window check: first mismatching position among the pattern bytes in use.
    always_comb
    begin
        mism     = 1'b0;
        mism_idx = '0;
        for (int i = PATTERN_MAX - 1; i >= 0; i--)
        begin
            if ((LEN_W'(i) < m_reg) && (win_reg[i] != cfg.pattern_bits[8*i +: 8]))
            begin
                mism     = 1'b1;
                mism_idx = LEN_W'(i);
            end
        end
        full_c  = (m_reg != '0) && (fill_reg >= m_reg);
        hit_c   = full_c && (wh_reg == target_reg);
        now_c   = hit_c ? (mism ? mism_idx + LEN_W'(1) : m_reg) : '0;
        pos_w   = 31'(pos_reg);
        mm1     = 31'(m_reg) - 31'd1;
        start_c = (full_c && pos_w >= mm1) ? pos_w - mm1 : '0;
        cc_sum  = {1'b0, cc_reg} + (CNT_W+1)'(now_c);
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        red_op      = OP_HOLD;
        red_bit     = 1'b0;
        red_operand = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (open_reg || m_new == '0)
                    begin
                        state_next = S_PROC;
                    end
                    else
                    begin
                        red_op     = OP_LOAD;
                        k_next     = '0;
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                red_op  = OP_SHIFT;
                red_bit = cfg.pattern_bits[{k_reg[7:3], ~k_reg[2:0]}];
                k_next  = k_reg + 8'd1;
                if ({1'b0, k_reg} == last_tgt)
                begin
                    state_next = S_TCAP;
                end
            end
            S_TCAP:
            begin
                red_op      = OP_LOAD;
                red_operand = MOD_W'(1);
                k_next      = '0;
                state_next  = (m_reg == LEN_W'(1)) ? S_LCAP : S_LFAC;
            end
            S_LFAC:
            begin
                red_op = OP_SHIFT;
                k_next = k_reg + 8'd1;
                if ({1'b0, k_reg} == last_lf)
                begin
                    state_next = S_LCAP;
                end
            end
            S_LCAP:
            begin
                state_next = S_PROC;
            end
            S_PROC:
            begin
                k_next = '0;
                if (m_reg == '0)
                begin
                    state_next = S_CHK;
                end
                else if (fill_reg < m_reg)
                begin
                    red_op      = OP_LOAD;
                    red_operand = wh_reg;
                    state_next  = S_HSH;
                end
                else
                begin
                    red_op     = OP_LOAD;
                    state_next = S_LEAD;
                end
            end
            S_LEAD:
            begin
                // Even steps double, odd steps add the leading factor when the bit is set.
                if (!k_reg[0])
                begin
                    red_op = OP_SHIFT;
                end
                else
                begin
                    red_op      = OP_ADD;
                    red_operand = win_reg[0][~k_reg[3:1]] ? lf_reg : '0;
                end
                k_next = k_reg + 8'd1;
                if (k_reg == 8'd15)
                begin
                    state_next = S_SUBT;
                end
            end
            S_SUBT:
            begin
                red_op      = OP_SUBR;
                red_operand = wh_reg;
                k_next      = '0;
                state_next  = S_HSH;
            end
            S_HSH:
            begin
                red_op  = OP_SHIFT;
                red_bit = q_item.text_byte[~k_reg[2:0]];
                k_next  = k_reg + 8'd1;
                if (k_reg == 8'd7)
                begin
                    state_next = S_WUPD;
                end
            end
            S_WUPD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            m_reg         <= LEN_RESET;
            q_reg         <= MOD_RESET;
            open_reg      <= 1'b0;
            wh_reg        <= '0;
            target_reg    <= '0;
            lf_reg        <= MOD_W'(1);
            fill_reg      <= '0;
            pos_reg       <= '0;
            cc_reg        <= '0;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (out_valid_reg && out_ready && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && !open_reg)
                    begin
                        m_reg <= m_new;
                        q_reg <= q_new;
                        if (m_new == '0)
                        begin
                            target_reg <= '0;
                            lf_reg     <= MOD_W'(1);
                            open_reg   <= 1'b1;
                        end
                    end
                end
                S_TCAP:
                begin
                    target_reg <= red_acc;
                end
                S_LCAP:
                begin
                    lf_reg   <= red_acc;
                    open_reg <= 1'b1;
                end
                S_WUPD:
                begin
                    wh_reg <= red_acc;
                    if (fill_reg < m_reg)
                    begin
                        fill_reg <= fill_reg + LEN_W'(1);
                    end
                end
                S_CHK:
                begin
                    if (hit_c)
                    begin
                        cc_reg <= (cc_sum > (CNT_W+1)'(CNT_SAT)) ? CNT_SAT : cc_sum[CNT_W-1:0];
                        if (!mism && fc_reg != FND_SAT)
                        begin
                            fc_reg <= fc_reg + FND_W'(1);
                        end
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        if (q_item.text_end)
                        begin
                            open_reg <= 1'b0;
                            wh_reg   <= '0;
                            fill_reg <= '0;
                            pos_reg  <= '0;
                            cc_reg   <= '0;
                            fc_reg   <= '0;
                        end
                        else if (pos_reg < POS_LAST)
                        begin
                            pos_reg <= pos_reg + POS_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Window bytes: filled in order, then shifted down by one with the new byte at the end.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WUPD)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                if (fill_reg < m_reg)
                begin
                    if (LEN_W'(i) == fill_reg)
                    begin
                        win_reg[i] <= q_item.text_byte;
                    end
                end
                else if (LEN_W'(i) == m_reg - LEN_W'(1))
                begin
                    win_reg[i] <= q_item.text_byte;
                end
                else if (i < PATTERN_MAX - 1)
                begin
                    win_reg[i] <= win_reg[(i + 1) % PATTERN_MAX];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHK)
        begin
            r_full_reg  <= full_c;
            r_hit_reg   <= hit_c;
            r_fnd_reg   <= hit_c && !mism;
            r_start_reg <= start_c[START_W-1:0];
            r_now_reg   <= now_c;
        end
        if (emit_go)
        begin
            full_reg  <= r_full_reg;
            hit_reg   <= r_hit_reg;
            fnd_reg   <= r_fnd_reg;
            start_reg <= r_start_reg;
            now_reg   <= r_now_reg;
            ctot_reg  <= cc_reg;
            ftot_reg  <= fc_reg;
            fin_reg   <= q_item.text_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_full   = full_reg;
    assign hash_hit      = hit_reg;
    assign found         = fnd_reg;
    assign match_start   = start_reg;
    assign compares_now  = now_reg;
    assign compare_total = ctot_reg;
    assign found_total   = ftot_reg;
    assign final_res     = fin_reg;

endmodule

>>> bench/tb_rolling_hash_substring_search_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the rolling-hash substring search top level.
// Depends on rhs_pkg and rolling_hash_substring_search_top; predicts every result itself.
module tb_rolling_hash_substring_search_top;
    import rhs_pkg::*;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } text_item_t;

    typedef struct packed {
        logic               window_full;
        logic               hash_hit;
        logic               found;
        logic [START_W-1:0] match_start;
        logic [LEN_W-1:0]   compares_now;
        logic [CNT_W-1:0]   compare_total;
        logic [FND_W-1:0]   found_total;
        logic               final_res;
    } search_result_t;

    localparam int TEXT_LIMIT  = 1048576;
    localparam int STALL_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         text_byte;
    logic               text_end;
    logic               out_valid;
    logic               out_ready;
    logic               window_full;
    logic               hash_hit;
    logic               found;
    logic [START_W-1:0] match_start;
    logic [LEN_W-1:0]   compares_now;
    logic [CNT_W-1:0]   compare_total;
    logic [FND_W-1:0]   found_total;
    logic               final_res;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [63:0]        cfg_data;

    rolling_hash_substring_search_top dut (.*);

    // Programmed registers and the per-text state of the predictor.
    logic [LEN_W-1:0] len_reg;
    logic [MOD_W-1:0] mod_reg;
    logic [63:0]      pat_word [4];
    logic [7:0]       win_bytes [32];
    longint unsigned  win_hash, pat_hash, lead_fac, text_mod;
    int unsigned      text_len, text_pos, win_fill, cmp_count, hit_count;
    bit               text_open;

    text_item_t      pending_bytes [$];
    search_result_t  expected_results [$];
    int              idle_pct;
    int              errors;
    int              stall_cycles;
    int              bytes_sent, results_seen, found_seen, hits_seen;

    always #1 clk = ~clk;

    function automatic logic [7:0] pattern_byte(int unsigned i);
        return pat_word[(i >> 3) & 3][(i & 7) * 8 +: 8];
    endfunction

    function automatic void clear_text();
        foreach (win_bytes[i]) win_bytes[i] = 8'd0;
        win_hash  = 0;
        pat_hash  = 0;
        lead_fac  = 1;
        text_pos  = 0;
        win_fill  = 0;
        cmp_count = 0;
        hit_count = 0;
        text_open = 0;
    endfunction

    function automatic search_result_t search_byte(text_item_t it);
        search_result_t  r;
        longint unsigned lead, h;
        int unsigned     j;
        r = '{default: '0};
        if (!text_open) begin
            text_len = (len_reg > 32) ? 32 : len_reg;
            text_mod = (mod_reg < MOD_MIN) ? MOD_MIN : mod_reg;
            pat_hash = 0;
            for (int i = 0; i < text_len; i++)
                pat_hash = (pat_hash * 256 + pattern_byte(i)) % text_mod;
            lead_fac = 1 % text_mod;
            for (int i = 1; i < text_len; i++)
                lead_fac = (lead_fac * 256) % text_mod;
            text_open = 1;
        end
        if (text_len > 0) begin
            if (win_fill < text_len) begin
                win_bytes[win_fill] = it.text_byte;
                win_hash = (win_hash * 256 + it.text_byte) % text_mod;
                win_fill++;
            end else begin
                lead = (longint'(win_bytes[0]) * lead_fac) % text_mod;
                h = (win_hash + text_mod - lead) % text_mod;
                for (int i = 0; i < text_len - 1; i++) win_bytes[i] = win_bytes[i + 1];
                win_bytes[text_len - 1] = it.text_byte;
                win_hash = (h * 256 + it.text_byte) % text_mod;
            end
            if (win_fill >= text_len) begin
                r.window_full = 1;
                r.match_start = (text_pos >= text_len - 1) ? text_pos - (text_len - 1) : 0;
                if (win_hash == pat_hash) begin
                    r.hash_hit = 1;
                    for (j = 0; j < text_len; j++) begin
                        r.compares_now++;
                        if (win_bytes[j] != pattern_byte(j)) break;
                    end
                    if (j == text_len) begin
                        r.found = 1;
                        if (hit_count < FND_SAT) hit_count++;
                    end
                    cmp_count = (cmp_count + r.compares_now > CNT_SAT) ? CNT_SAT
                                : cmp_count + r.compares_now;
                end
            end
        end
        if (text_pos < TEXT_LIMIT - 1) text_pos++;
        r.compare_total = cmp_count;
        r.found_total   = hit_count;
        r.final_res     = it.text_end;
        if (it.text_end) clear_text();
        return r;
    endfunction

    // Byte driver: predicts each transaction as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            text_byte <= 8'd0;
            text_end  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(search_byte('{text_byte, text_end}));
                bytes_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    text_item_t nxt;
                    nxt = pending_bytes.pop_front();
                    in_valid  <= 1'b1;
                    text_byte <= nxt.text_byte;
                    text_end  <= nxt.text_end;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                search_result_t got, exp;
                got = '{window_full, hash_hit, found, match_start, compares_now,
                        compare_total, found_total, final_res};
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction", $time);
                    errors++;
                end
                else
                begin
                    exp = expected_results.pop_front();
                    if (got != exp)
                    begin
                        $display("%0t: result mismatch, expected %p actual %p", $time, exp, got);
                        errors++;
                    end
                    found_seen += got.found;
                    hits_seen  += got.hash_hit;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_LEN: len_reg = d[LEN_W-1:0];
            REG_MOD: mod_reg = d[MOD_W-1:0];
            default: pat_word[idx - REG_WORD_0] = d;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic push_text(string s, bit closed);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back('{s[i], closed && (i == s.len() - 1)});
    endtask

    // Random text, biased towards copies of the pattern and near-misses of it.
    task automatic push_random_text(int n, bit closed);
        int unsigned m, k;
        m = (len_reg > 32) ? 32 : len_reg;
        k = 0;
        while (k < n) begin
            if (m > 0 && $urandom_range(0, 3) == 0) begin
                for (int i = 0; i < m && k < n; i++, k++)
                    pending_bytes.push_back('{(i == m - 1 && $urandom_range(0, 2) == 0)
                        ? pattern_byte(i) ^ 8'(1 << $urandom_range(0, 7)) : pattern_byte(i),
                        closed && k == n - 1});
            end else begin
                pending_bytes.push_back('{(m > 0 && $urandom_range(0, 1))
                    ? pattern_byte($urandom_range(0, m - 1)) : 8'($urandom),
                    closed && k == n - 1});
                k++;
            end
        end
    endtask

    initial
    begin
        int unsigned q_choice;
        clk = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 36;
        errors = 0;
        stall_cycles = 0;
        bytes_sent = 0;
        results_seen = 0;
        found_seen = 0;
        hits_seen = 0;
        len_reg = LEN_RESET;
        mod_reg = MOD_RESET;
        foreach (pat_word[i]) pat_word[i] = '0;
        clear_text();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, a zero pattern of length one.
        pending_bytes.push_back('{8'h00, 1'b0});
        pending_bytes.push_back('{8'hFF, 1'b0});
        pending_bytes.push_back('{8'h00, 1'b1});
        wait_drained();
        // Modulus below the minimum is raised to 2, so a hash is the last byte's parity.
        write_reg(REG_LEN, 64'hFFFF_FFFF_FFFF_FFC3);
        write_reg(REG_LEN, 64'd3);
        write_reg(REG_MOD, 64'd1);
        write_reg(REG_WORD_0, 64'h0000_0000_0063_6261);
        push_text("xabcabx", 1);
        wait_drained();
        // Zero length disables matching.
        write_reg(REG_LEN, 64'd0);
        push_text("abc", 1);
        wait_drained();
        // Largest modulus with a five-byte pattern of all-ones bytes.
        write_reg(REG_MOD, 64'hFFFF_FFFF_7FFF_FFFF);
        write_reg(REG_LEN, 64'd5);
        write_reg(REG_WORD_0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_text("\377\377\377\377\377\000\377", 1);
        wait_drained();

        // Random phases: each changes the settings and sends a few texts.
        for (int ph = 0; ph < 14; ph++)
        begin
            idle_pct = (ph == 6) ? 0 : 36;
            case (ph % 4)
                0: q_choice = $urandom_range(0, 3);
                1: q_choice = $urandom_range(2, 300);
                2: q_choice = 32'h7FFF_FFFF;
                default: q_choice = $urandom_range(1000, 32'h7FFF_FFFF);
            endcase
            write_reg(REG_MOD, {$urandom, 1'b0, q_choice[30:0]});
            if (ph == 3) write_reg(REG_LEN, {$urandom, $urandom_range(33, 63)});
            else if (ph == 9) write_reg(REG_LEN, 64'd32);
            else if (ph == 11) write_reg(REG_LEN, 64'd0);
            else write_reg(REG_LEN, $urandom_range(1, 8));
            for (int w = 0; w < 4; w++)
                write_reg(reg_idx_t'(REG_WORD_0 + w),
                          (ph % 5 == 4) ? {$urandom, $urandom} : {8{8'($urandom_range(0, 3))}}
                          ^ {$urandom, $urandom} & {8{8'h01}});
            for (int t = 0; t < 3; t++)
                push_random_text($urandom_range(1, 42), !(t == 2 && ph % 3 == 1));
            if (ph == 9) push_random_text(40, 1);
            // The sender holds off here until every result of the phase is back.
            wait_drained();
        end

        repeat (100) @(posedge clk);
        $display("Sent %0d bytes over 18 settings; %0d hash hits, %0d matches found.",
                 bytes_sent, hits_seen, found_seen);
        $display("Covered zero, oversized and full pattern lengths, and extreme moduli.");
        if (errors == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
